### design/nls_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// nls_pkg
// Shared types and constants of the natural logarithm series unit.
// ============================================================================
package nls_pkg;

  // Fraction bits of the internal series arithmetic.
  localparam int IW = 30;
  // Width of the divider step counter, which counts 0 .. IW-1.
  localparam int STEP_W = $clog2(IW);

  // Width and reset value of the term count register.
  localparam int TERM_W = 12;
  localparam logic [TERM_W-1:0] TERM_RESET = 12'd32;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,   // waiting for an argument
    ST_ZDIV,   // restoring division for |z|
    ST_SQR,    // z^2 on the multiplier
    ST_TLOAD,  // start the next term or finish
    ST_TDIV,   // restoring division of the power by the odd number
    ST_FIN     // convert, saturate and hand over the result
  } nls_state_e;

endpackage

### design/natural_log_series_unit.sv
`timescale 1ns / 1ps
// ============================================================================
// natural_log_series_unit
// Fixed-point natural logarithm by the inverse hyperbolic tangent series.
// ============================================================================
//
// The unit takes an unsigned argument x with FRAC_BITS fraction bits on the
// slave stream and returns ln(x) as a signed value with FRAC_BITS fraction
// bits on the master stream. It forms z = (x - 1) / (x + 1) and sums
// 2 * z^(2k+1) / (2k+1) over the number of terms held in the term count
// register (reset value 32, clamped to MAX_TERMS). An argument of zero returns
// zero with the invalid flag set in tuser. All work is done by one restoring
// divider step, used once per cycle, and one 30 by 30 multiplier, under a
// small sequencer, so one request is processed at a time and the slave side
// is not ready while it is at work. For a nonzero argument the divider first
// forms |z| and the multiplier then forms z^2. Each term, up to the clamped
// term count, starts with a load in which the next power is formed on the
// multiplier, and goes on with the division of the current power by the odd
// number on the divider. A zero argument goes straight from idle to the
// final state. The finished result sits in an output register, and the unit
// takes the next request while it waits there; a second result waits in the
// final state until the first is taken. The term count register may only be
// written while the unit is idle.
//
module natural_log_series_unit #(
  parameter int FRAC_BITS = 24,
  parameter int MAX_TERMS = 4095
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Configuration: term count.
  input  logic                            cfg_we_i,
  input  logic [nls_pkg::TERM_W-1:0]      cfg_wdata_i,
  // Argument stream.
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  input  logic [31:0]                     s_axis_tdata_i,   // [31:0] x_value
  // Result stream.
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  output logic signed [31:0]              m_axis_tdata_o,   // [31:0] log_value
  output logic                            m_axis_tuser_o    // [0] invalid
);

  localparam int IW     = nls_pkg::IW;
  // Width that holds x + one.
  localparam int ARG_W  = ((FRAC_BITS >= 32) ? FRAC_BITS : 32) + 1;
  // Term counter width; it must hold the clamped term count itself.
  localparam int CNT_W  = $clog2(MAX_TERMS + 1);
  // Divisor and remainder width, covering both x + one and 2k + 1.
  localparam int DEN_W  = (ARG_W > CNT_W + 1) ? ARG_W : CNT_W + 1;
  // Every term is below 2^IW, and there are fewer than 2^CNT_W of them.
  localparam int SUM_W  = IW + CNT_W;
  // Output conversion shifts.
  localparam int SH_R   = (FRAC_BITS < IW) ? IW - FRAC_BITS : 0;
  localparam int SH_L   = (FRAC_BITS >= IW) ? FRAC_BITS - IW : 0;
  localparam int MAG_W  = SUM_W + SH_L + 2;
  localparam int HALF_POS = (SH_R > 0) ? SH_R - 1 : 0;
  localparam logic [MAG_W-1:0] HALF =
    (SH_R > 0) ? (MAG_W'(1) << HALF_POS) : '0;
  localparam logic [MAG_W-1:0] POS_LIM = MAG_W'(64'h0000_0000_7FFF_FFFF);
  localparam logic [MAG_W-1:0] NEG_LIM = MAG_W'(64'h0000_0000_8000_0000);
  localparam logic [ARG_W-1:0] ONE = ARG_W'(1) << FRAC_BITS;
  localparam logic [nls_pkg::STEP_W-1:0] LAST_STEP = nls_pkg::STEP_W'(IW - 1);

  nls_pkg::nls_state_e state_q, state_d;

  logic [nls_pkg::TERM_W-1:0] term_count_q;
  logic [DEN_W-1:0]           rem_q, rem_d;
  logic [DEN_W-1:0]           den_q, den_d;
  logic [IW-1:0]              quo_q, quo_d;
  logic [nls_pkg::STEP_W-1:0] step_q, step_d;
  logic [IW-1:0]              pw_q, pw_d;
  logic [IW-1:0]              z2_q, z2_d;
  logic [CNT_W-1:0]           k_q, k_d;
  logic [SUM_W-1:0]           sum_q, sum_d;
  logic                       neg_q, neg_d;
  logic                       inv_q, inv_d;
  logic                       out_valid_q, out_valid_d;
  logic signed [31:0]         out_data_q, out_data_d;
  logic                       out_inv_q, out_inv_d;

  logic                       s_fire;
  logic                       slot_free;
  logic                       last_step;
  logic                       terms_done;
  logic [CNT_W-1:0]           n_terms;

  // Argument preparation.
  logic [ARG_W-1:0]           x_ext;
  logic                       x_below_one;
  logic [ARG_W-1:0]           z_num;
  logic [ARG_W-1:0]           z_den;

  // Shared divider step.
  logic [DEN_W:0]             div_trial;
  logic [DEN_W:0]             div_diff;
  logic                       div_take;
  logic [DEN_W-1:0]           div_rem;
  logic [IW-1:0]              div_quo;

  // Shared multiplier.
  logic [IW-1:0]              mul_b;
  logic [2*IW-1:0]            mul_p;

  // Output conversion.
  logic [MAG_W-1:0]           mag_full;
  logic [MAG_W-1:0]           mag_sat;
  logic [31:0]                mag32;

  assign s_axis_tready_o = (state_q == nls_pkg::ST_IDLE);
  assign s_fire          = s_axis_tvalid_i && s_axis_tready_o;
  assign slot_free       = !out_valid_q || m_axis_tready_i;
  assign last_step       = (step_q == LAST_STEP);

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_inv_q;

  // The register is 12 bits wide, so the clamp is only active when MAX_TERMS
  // is below 4095.
  assign n_terms = (32'(term_count_q) > 32'(MAX_TERMS)) ? CNT_W'(MAX_TERMS)
                                                        : CNT_W'(term_count_q);
  assign terms_done = (k_q == n_terms);

  assign x_ext       = ARG_W'(s_axis_tdata_i);
  assign x_below_one = (x_ext < ONE);
  assign z_num       = x_below_one ? (ONE - x_ext) : (x_ext - ONE);
  assign z_den       = x_ext + ONE;

  // One restoring division step. The quotient register doubles as the
  // dividend shift register: for |z| it starts at zero and the remainder
  // starts at the numerator, for a term the remainder starts at zero and
  // the power is shifted in from the top.
  assign div_trial = {rem_q, quo_q[IW-1]};
  assign div_diff  = div_trial - {1'b0, den_q};
  assign div_take  = !div_diff[DEN_W];
  assign div_rem   = div_take ? div_diff[DEN_W-1:0] : div_trial[DEN_W-1:0];
  assign div_quo   = {quo_q[IW-2:0], div_take};

  // The power register holds |z| while z^2 is formed.
  assign mul_b = (state_q == nls_pkg::ST_SQR) ? pw_q : z2_q;
  assign mul_p = pw_q * mul_b;

  // Double the sum, rescale to FRAC_BITS with round half up, then saturate
  // toward the representable range of the signed result.
  assign mag_full = ((MAG_W'(sum_q) << (SH_L + 1)) + HALF) >> SH_R;
  always_comb begin
    if (neg_q) begin
      mag_sat = (mag_full > NEG_LIM) ? NEG_LIM : mag_full;
    end else begin
      mag_sat = (mag_full > POS_LIM) ? POS_LIM : mag_full;
    end
  end
  assign mag32 = mag_sat[31:0];

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      nls_pkg::ST_IDLE: begin
        if (s_fire) begin
          state_d = (s_axis_tdata_i == 32'd0) ? nls_pkg::ST_FIN : nls_pkg::ST_ZDIV;
        end
      end
      nls_pkg::ST_ZDIV: begin
        if (last_step) begin
          state_d = nls_pkg::ST_SQR;
        end
      end
      nls_pkg::ST_SQR: begin
        state_d = nls_pkg::ST_TLOAD;
      end
      nls_pkg::ST_TLOAD: begin
        state_d = terms_done ? nls_pkg::ST_FIN : nls_pkg::ST_TDIV;
      end
      nls_pkg::ST_TDIV: begin
        if (last_step) begin
          state_d = nls_pkg::ST_TLOAD;
        end
      end
      nls_pkg::ST_FIN: begin
        if (slot_free) begin
          state_d = nls_pkg::ST_IDLE;
        end
      end
      default: state_d = nls_pkg::ST_IDLE;
    endcase
  end

  // Datapath control.
  always_comb begin
    rem_d       = rem_q;
    den_d       = den_q;
    quo_d       = quo_q;
    step_d      = step_q;
    pw_d        = pw_q;
    z2_d        = z2_q;
    k_d         = k_q;
    sum_d       = sum_q;
    neg_d       = neg_q;
    inv_d       = inv_q;
    out_data_d  = out_data_q;
    out_inv_d   = out_inv_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    unique case (state_q)
      nls_pkg::ST_IDLE: begin
        if (s_fire) begin
          rem_d  = DEN_W'(z_num);
          den_d  = DEN_W'(z_den);
          quo_d  = '0;
          step_d = '0;
          sum_d  = '0;
          neg_d  = x_below_one;
          inv_d  = (s_axis_tdata_i == 32'd0);
        end
      end
      nls_pkg::ST_ZDIV: begin
        rem_d  = div_rem;
        quo_d  = div_quo;
        step_d = step_q + 1'b1;
        if (last_step) begin
          pw_d = div_quo;
        end
      end
      nls_pkg::ST_SQR: begin
        z2_d = mul_p[2*IW-1:IW];
        k_d  = '0;
      end
      nls_pkg::ST_TLOAD: begin
        if (!terms_done) begin
          rem_d  = '0;
          quo_d  = pw_q;
          den_d  = DEN_W'({k_q, 1'b1});
          step_d = '0;
          pw_d   = mul_p[2*IW-1:IW];
        end
      end
      nls_pkg::ST_TDIV: begin
        rem_d  = div_rem;
        quo_d  = div_quo;
        step_d = step_q + 1'b1;
        if (last_step) begin
          sum_d = sum_q + SUM_W'(div_quo);
          k_d   = k_q + 1'b1;
        end
      end
      nls_pkg::ST_FIN: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_inv_d   = inv_q;
          if (inv_q) begin
            out_data_d = '0;
          end else if (neg_q) begin
            out_data_d = $signed(32'd0 - mag32);
          end else begin
            out_data_d = $signed(mag32);
          end
        end
      end
      default: begin
        out_valid_d = out_valid_q && !m_axis_tready_i;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= nls_pkg::ST_IDLE;
      out_valid_q  <= 1'b0;
      term_count_q <= nls_pkg::TERM_RESET;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        term_count_q <= cfg_wdata_i;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    rem_q      <= rem_d;
    den_q      <= den_d;
    quo_q      <= quo_d;
    step_q     <= step_d;
    pw_q       <= pw_d;
    z2_q       <= z2_d;
    k_q        <= k_d;
    sum_q      <= sum_d;
    neg_q      <= neg_d;
    inv_q      <= inv_d;
    out_data_q <= out_data_d;
    out_inv_q  <= out_inv_d;
  end

endmodule

### design/nls_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// nls_checker
// Port-level assertions for the natural logarithm series unit.
// ============================================================================
module nls_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [31:0] m_axis_tdata_o,
  input logic        m_axis_tuser_o
);

  // A request keeps the unit busy for at least the following cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("slave side ready right after accepting a request");

  // An invalid result always carries a zero logarithm.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o) |-> (m_axis_tdata_o == 32'd0))
    else $error("invalid result with nonzero data");

  // A stalled result stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> m_axis_tvalid_o)
    else $error("result withdrawn while stalled");

  // A stalled result holds its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=>
      ($stable(m_axis_tdata_o) && $stable(m_axis_tuser_o)))
    else $error("result payload changed while stalled");

endmodule

bind natural_log_series_unit nls_checker u_nls_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);
